[hw/rtl/sconv_pkg.sv]
// Shared types, codes and width helpers for the strided 1-D convolution block.
package sconv_pkg;

   localparam int VAL_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W = 48;
   localparam int OUT_W = 32;
   localparam int POS_W = 16;
   localparam int FILT_W = 4;
   localparam int CHAN_W = 3;
   localparam int TAP_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 5;

   localparam int DEF_MAX_IN_CH = 8;
   localparam int DEF_MAX_OUT_CH = 16;
   localparam int DEF_MAX_TAPS = 8;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KERNEL_LEN   = 3'd0,
      REG_STEP_LEN     = 3'd1,
      REG_IN_CHANNELS  = 3'd2,
      REG_OUT_CHANNELS = 3'd3
   } reg_idx_type;

   // per-word pipeline tag: one (filter, channel) pair
   typedef struct packed {
      logic              vld;
      logic              first;
      logic              last;
      logic              fend;
      logic [FILT_W-1:0] filt;
   } sconv_tag_type;

   function automatic int addr_w(input int n);
      return (n <= 1) ? 1 : $clog2(n);
   endfunction

endpackage

[hw/rtl/sconv_wmem.sv]
// Weight memory (one row of all taps per filter and channel) and bias memory.
module sconv_wmem import sconv_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int FW = 4,
   parameter int CW = 3,
   parameter int TW = 3
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [FW-1:0]                    wr_f,
   input  logic [CW-1:0]                    wr_c,
   input  logic [TW-1:0]                    wr_t,
   input  logic [VAL_W-1:0]                 wr_data,
   input  logic                             bwr_en,
   input  logic [FW-1:0]                    bwr_f,
   input  logic                             rd_en,
   input  logic [FW-1:0]                    rd_f,
   input  logic [CW-1:0]                    rd_c,
   output logic [MAX_TAPS-1:0][VAL_W-1:0]   rd_row,
   output logic [VAL_W-1:0]                 rd_bias
);

   logic [MAX_TAPS-1:0][VAL_W-1:0] w_mem [2**(FW+CW)];
   logic [VAL_W-1:0]               b_mem [2**FW];
   logic [MAX_TAPS-1:0][VAL_W-1:0] rd_row_ff;
   logic [VAL_W-1:0]               rd_bias_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         w_mem[{wr_f, wr_c}][wr_t] <= wr_data;
      end
      if (rd_en) begin
         rd_row_ff <= w_mem[{rd_f, rd_c}];
      end
   end

   always_ff @(posedge clock) begin
      if (bwr_en) begin
         b_mem[bwr_f] <= wr_data;
      end
      if (rd_en) begin
         rd_bias_ff <= b_mem[rd_f];
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_bias = rd_bias_ff;

endmodule

[hw/rtl/sconv_hist.sv]
// Column history memory (one row of all ring slots per channel) with valid bits.
module sconv_hist import sconv_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int CW = 3,
   parameter int TW = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [TW-1:0]                    wr_slot,
   input  logic [CW-1:0]                    wr_ch,
   input  logic [VAL_W-1:0]                 wr_data,
   input  logic                             clr_row_en,
   input  logic [TW-1:0]                    clr_slot,
   input  logic                             clr_all,
   input  logic                             rd_en,
   input  logic [CW-1:0]                    rd_ch,
   output logic [MAX_TAPS-1:0][VAL_W-1:0]   rd_row,
   output logic [MAX_TAPS-1:0]              rd_vld
);

   logic [MAX_TAPS-1:0][VAL_W-1:0]   h_mem [2**CW];
   logic [MAX_TAPS-1:0][2**CW-1:0]   vld_ff, vld_in;
   logic [MAX_TAPS-1:0][VAL_W-1:0]   rd_row_ff;
   logic [MAX_TAPS-1:0]              rd_vld_ff, rd_vld_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         h_mem[wr_ch][wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_row_ff <= h_mem[rd_ch];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_slot][wr_ch] = 1'b1;
      end
      if (clr_row_en) begin
         vld_in[clr_slot] = '0;
      end
      if (clr_all) begin
         vld_in = '0;
      end
      for (int t = 0; t < MAX_TAPS; t++) begin
         rd_vld_in[t] = vld_ff[t][rd_ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rd_vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= rd_vld_in;
         end
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_vld = rd_vld_ff;

endmodule

[hw/rtl/sconv_mac.sv]
// Tap-parallel multiply, lane sum, accumulate, saturate and result register.
module sconv_mac import sconv_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int TW = 3,
   parameter int KW = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sconv_tag_type                    tag0,
   input  logic [MAX_TAPS-1:0][VAL_W-1:0]   w_row,
   input  logic [VAL_W-1:0]                 bias,
   input  logic [MAX_TAPS-1:0][VAL_W-1:0]   h_row,
   input  logic [MAX_TAPS-1:0]              h_vld,
   input  logic [TW-1:0]                    base,
   input  logic [KW-1:0]                    k_eff,
   input  logic [POS_W-1:0]                 pos,
   output logic                             adv,
   output logic                             busy,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [FILT_W-1:0]                rsp_out_filter,
   output logic [POS_W-1:0]                 rsp_out_position,
   output logic signed [OUT_W-1:0]          rsp_out_value,
   output logic                             rsp_last_of_column
);

   localparam int PSW = PROD_W + TW + 1;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   sconv_tag_type tag1_ff, tag2_ff, tag3_ff;
   logic signed [PROD_W-1:0] prod_ff [MAX_TAPS];
   logic signed [PROD_W-1:0] prod_in [MAX_TAPS];
   logic signed [VAL_W-1:0]  bias2_ff, bias3_ff;
   logic signed [PSW-1:0]    psum_ff, psum_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_base, tot;
   logic signed [OUT_W-1:0]  sat_val;
   logic                     rsp_valid_ff;
   logic [FILT_W-1:0]        filt_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [OUT_W-1:0]  val_ff;
   logic                     lastc_ff;
   logic signed [VAL_W-1:0]  hv [MAX_TAPS];

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign busy = tag1_ff.vld || tag2_ff.vld || tag3_ff.vld;

   always_comb begin
      int sl;
      for (int t = 0; t < MAX_TAPS; t++) begin
         sl = int'(base) + t;
         if (sl >= MAX_TAPS) begin
            sl = sl - MAX_TAPS;
         end
         if ((t < int'(k_eff)) && h_vld[TW'(sl)]) begin
            hv[t] = h_row[TW'(sl)];
         end else begin
            hv[t] = '0;
         end
         prod_in[t] = hv[t] * $signed(w_row[t]);
      end
   end

   always_comb begin
      psum_in = '0;
      for (int t = 0; t < MAX_TAPS; t++) begin
         psum_in = psum_in + PSW'(prod_ff[t]);
      end
   end

   always_comb begin
      acc_base = tag3_ff.first ? (ACC_W'(bias3_ff) <<< 8) : acc_ff;
      tot = acc_base + ACC_W'(psum_ff);
      if (tot > SAT_HI) begin
         sat_val = OUT_W'(SAT_HI);
      end else if (tot < SAT_LO) begin
         sat_val = OUT_W'(SAT_LO);
      end else begin
         sat_val = OUT_W'(tot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            tag1_ff <= tag0;
            tag2_ff <= tag1_ff;
            tag3_ff <= tag2_ff;
         end
         if (adv && tag3_ff.vld && tag3_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < MAX_TAPS; t++) begin
            prod_ff[t] <= prod_in[t];
         end
         bias2_ff <= bias;
         bias3_ff <= bias2_ff;
         psum_ff <= psum_in;
         if (tag3_ff.vld) begin
            acc_ff <= tot;
         end
         if (tag3_ff.vld && tag3_ff.last) begin
            filt_ff <= tag3_ff.filt;
            pos_ff <= pos;
            val_ff <= sat_val;
            lastc_ff <= tag3_ff.fend;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_filter = filt_ff;
   assign rsp_out_position = pos_ff;
   assign rsp_out_value = val_ff;
   assign rsp_last_of_column = lastc_ff;

endmodule

[hw/rtl/strided_conv1d_stream.sv]
// Strided multichannel 1-D convolution: top level, control sequencer and registers.
//
// Input words (req_*) load weights and biases or stream samples channel by channel;
// column_end closes a column, sequence_end clears history and counters after the word.
// Result words (rsp_*) carry one sum per output channel, last_of_column on the last.
// Registers are written through csr_* (index, data); csr_ready is always high, and
// writes are expected only while the block is idle.
// Load words and samples that close no output position leave the block idle, req_stall low.
// A column that completes an output position reads, for each output and input channel
// pair, one weight row and one history row per cycle while no stalled result holds it
// (all taps in parallel), then drains the pipeline and does its bookkeeping; req_stall
// is high meanwhile. Each sum passes the memory read, product and lane-sum registers
// into the result register; results come one per output channel.
// A stalled result holds the output register and freezes the read pipeline.
// Reset clears history valid bits, counters and registers to their reset values;
// weight and bias memories are not cleared and must be loaded before use.
module strided_conv1d_stream import sconv_pkg::*; #(
   parameter int MAX_IN_CH = DEF_MAX_IN_CH,
   parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
   parameter int MAX_TAPS = DEF_MAX_TAPS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic [FILT_W-1:0]          req_filter_index,
   input  logic [CHAN_W-1:0]          req_channel_index,
   input  logic [TAP_W-1:0]           req_tap_index,
   input  logic signed [VAL_W-1:0]    req_value,
   input  logic                       req_column_end,
   input  logic                       req_sequence_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [FILT_W-1:0]          rsp_out_filter,
   output logic [POS_W-1:0]           rsp_out_position,
   output logic signed [OUT_W-1:0]    rsp_out_value,
   output logic                       rsp_last_of_column,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int LIM_OUT = (MAX_OUT_CH < 16) ? MAX_OUT_CH : 16;
   localparam int LIM_IN = (MAX_IN_CH < 8) ? MAX_IN_CH : 8;
   localparam int FW = addr_w(LIM_OUT);
   localparam int CW = addr_w(LIM_IN);
   localparam int TW = addr_w(MAX_TAPS);
   localparam int KW = $clog2(MAX_TAPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [3:0]        kern_ff, step_ff, inch_ff;
   logic [4:0]        outch_ff;
   logic [TW-1:0]     ws_ff, ws_in, ws_next, base_ff, base_in;
   logic [POS_W-1:0]  cs_ff, cs_in, cs_sat;
   logic [2:0]        phase_ff, phase_in;
   logic [3:0]        phase_inc, phase_mod;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              seqend_ff, seqend_in;
   logic [FILT_W-1:0] f_ctr_ff, f_ctr_in;
   logic [CHAN_W-1:0] c_ctr_ff, c_ctr_in;

   logic [KW-1:0]     k_eff;
   logic [3:0]        s_eff, nin_eff;
   logic [4:0]        nout_eff;
   logic              req_accept, emit;
   logic              w_wr, b_wr, h_wr, clr_row_en, clr_all;
   logic [TW-1:0]     clr_slot;
   sconv_tag_type     tag0;
   logic              adv, busy;

   logic [MAX_TAPS-1:0][VAL_W-1:0] w_row, h_row;
   logic [MAX_TAPS-1:0]            h_vld;
   logic [VAL_W-1:0]               bias;

   // effective register values
   always_comb begin
      if (kern_ff == '0) begin
         k_eff = KW'(1);
      end else if (int'(kern_ff) > MAX_TAPS) begin
         k_eff = KW'(MAX_TAPS);
      end else begin
         k_eff = KW'(kern_ff);
      end
      if (step_ff == '0) begin
         s_eff = 4'd1;
      end else if (step_ff > 4'd8) begin
         s_eff = 4'd8;
      end else begin
         s_eff = step_ff;
      end
      if (inch_ff == '0) begin
         nin_eff = 4'd1;
      end else if (int'(inch_ff) > LIM_IN) begin
         nin_eff = 4'(LIM_IN);
      end else begin
         nin_eff = inch_ff;
      end
      if (outch_ff == '0) begin
         nout_eff = 5'd1;
      end else if (int'(outch_ff) > LIM_OUT) begin
         nout_eff = 5'(LIM_OUT);
      end else begin
         nout_eff = outch_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign ws_next = (int'(ws_ff) == MAX_TAPS - 1) ? '0 : TW'(int'(ws_ff) + 1);
   assign cs_sat = (cs_ff == '1) ? cs_ff : cs_ff + POS_W'(1);
   assign phase_inc = {1'b0, phase_ff} + 4'd1;

   // phase may exceed a step that was shortened; at most four wraps for steps of two up
   always_comb begin
      phase_mod = phase_inc;
      if (s_eff == 4'd1) begin
         phase_mod = '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (phase_mod >= s_eff) begin
               phase_mod = phase_mod - s_eff;
            end
         end
      end
   end

   always_comb begin
      tag0.vld = (state_ff == ST_RUN);
      tag0.first = (c_ctr_ff == '0);
      tag0.last = ({1'b0, c_ctr_ff} == nin_eff - 4'd1);
      tag0.fend = ({1'b0, f_ctr_ff} == nout_eff - 5'd1);
      tag0.filt = f_ctr_ff;
   end

   always_comb begin
      state_in = state_ff;
      ws_in = ws_ff;
      cs_in = cs_ff;
      phase_in = phase_ff;
      pos_in = pos_ff;
      base_in = base_ff;
      seqend_in = seqend_ff;
      f_ctr_in = f_ctr_ff;
      c_ctr_in = c_ctr_ff;
      w_wr = 1'b0;
      b_wr = 1'b0;
      h_wr = 1'b0;
      clr_row_en = 1'b0;
      clr_slot = ws_next;
      clr_all = 1'b0;
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd_type'(req_cmd))
                  CMD_WEIGHT: begin
                     w_wr = (int'(req_filter_index) < MAX_OUT_CH) &&
                            (int'(req_channel_index) < MAX_IN_CH) &&
                            (int'(req_tap_index) < MAX_TAPS);
                  end
                  CMD_BIAS: begin
                     b_wr = (int'(req_filter_index) < MAX_OUT_CH);
                  end
                  CMD_SAMPLE: begin
                     h_wr = (int'(req_channel_index) < MAX_IN_CH);
                     if (req_column_end) begin
                        ws_in = ws_next;
                        cs_in = cs_sat;
                        if (int'(cs_sat) >= int'(k_eff)) begin
                           emit = (phase_ff == '0);
                           phase_in = phase_mod[2:0];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (emit) begin
                  state_in = ST_RUN;
                  f_ctr_in = '0;
                  c_ctr_in = '0;
                  seqend_in = req_sequence_end;
                  if (int'(ws_next) >= int'(k_eff)) begin
                     base_in = TW'(int'(ws_next) - int'(k_eff));
                  end else begin
                     base_in = TW'(int'(ws_next) + MAX_TAPS - int'(k_eff));
                  end
               end else begin
                  clr_row_en = (cmd_type'(req_cmd) == CMD_SAMPLE) && req_column_end;
                  if (req_sequence_end) begin
                     clr_all = 1'b1;
                     ws_in = '0;
                     cs_in = '0;
                     phase_in = '0;
                     pos_in = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (tag0.last) begin
                  c_ctr_in = '0;
                  if (tag0.fend) begin
                     state_in = ST_DRAIN;
                  end else begin
                     f_ctr_in = f_ctr_ff + FILT_W'(1);
                  end
               end else begin
                  c_ctr_in = c_ctr_ff + CHAN_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            clr_row_en = 1'b1;
            clr_slot = ws_ff;
            pos_in = (pos_ff == '1) ? pos_ff : pos_ff + POS_W'(1);
            if (seqend_ff) begin
               clr_all = 1'b1;
               ws_in = '0;
               cs_in = '0;
               phase_in = '0;
               pos_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ws_ff <= '0;
         cs_ff <= '0;
         phase_ff <= '0;
         pos_ff <= '0;
         seqend_ff <= 1'b0;
         f_ctr_ff <= '0;
         c_ctr_ff <= '0;
         kern_ff <= 4'd3;
         step_ff <= 4'd1;
         inch_ff <= 4'd8;
         outch_ff <= 5'd16;
      end else begin
         state_ff <= state_in;
         ws_ff <= ws_in;
         cs_ff <= cs_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         seqend_ff <= seqend_in;
         f_ctr_ff <= f_ctr_in;
         c_ctr_ff <= c_ctr_in;
         if (csr_valid && csr_ready) begin
            case (reg_idx_type'(csr_index))
               REG_KERNEL_LEN:   kern_ff <= csr_data[3:0];
               REG_STEP_LEN:     step_ff <= csr_data[3:0];
               REG_IN_CHANNELS:  inch_ff <= csr_data[3:0];
               REG_OUT_CHANNELS: outch_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   sconv_wmem #(
      .MAX_TAPS (MAX_TAPS),
      .FW       (FW),
      .CW       (CW),
      .TW       (TW)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (w_wr),
      .wr_f    (FW'(req_filter_index)),
      .wr_c    (CW'(req_channel_index)),
      .wr_t    (TW'(req_tap_index)),
      .wr_data (req_value),
      .bwr_en  (b_wr),
      .bwr_f   (FW'(req_filter_index)),
      .rd_en   (adv),
      .rd_f    (FW'(f_ctr_ff)),
      .rd_c    (CW'(c_ctr_ff)),
      .rd_row  (w_row),
      .rd_bias (bias)
   );

   sconv_hist #(
      .MAX_TAPS (MAX_TAPS),
      .CW       (CW),
      .TW       (TW)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (h_wr),
      .wr_slot    (ws_ff),
      .wr_ch      (CW'(req_channel_index)),
      .wr_data    (req_value),
      .clr_row_en (clr_row_en),
      .clr_slot   (clr_slot),
      .clr_all    (clr_all),
      .rd_en      (adv),
      .rd_ch      (CW'(c_ctr_ff)),
      .rd_row     (h_row),
      .rd_vld     (h_vld)
   );

   sconv_mac #(
      .MAX_TAPS (MAX_TAPS),
      .TW       (TW),
      .KW       (KW)
   ) u_mac (
      .clock              (clock),
      .reset              (reset),
      .tag0               (tag0),
      .w_row              (w_row),
      .bias               (bias),
      .h_row              (h_row),
      .h_vld              (h_vld),
      .base               (base_ff),
      .k_eff              (k_eff),
      .pos                (pos_ff),
      .adv                (adv),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_filter     (rsp_out_filter),
      .rsp_out_position   (rsp_out_position),
      .rsp_out_value      (rsp_out_value),
      .rsp_last_of_column (rsp_last_of_column)
   );

endmodule

[tb/testbench.sv]
// Self-checking testbench for strided_conv1d_stream: random and directed words against a predictor.
module testbench;
   import sconv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type      kind;
      cmd_type          cmd;
      logic [3:0]       filt;
      logic [2:0]       chan;
      logic [2:0]       tap;
      logic [15:0]      val;
      logic             col_end;
      logic             seq_end;
      reg_idx_type      ridx;
      logic [4:0]       rdata;
   } op_type;

   typedef struct {
      logic [3:0]         filt;
      logic [15:0]        pos;
      logic signed [31:0] val;
      logic               last;
   } conv_out_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = 0;
   logic [3:0] req_filter_index = 0;
   logic [2:0] req_channel_index = 0;
   logic [2:0] req_tap_index = 0;
   logic signed [15:0] req_value = 0;
   logic req_column_end = 0;
   logic req_sequence_end = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [3:0] rsp_out_filter;
   logic [15:0] rsp_out_position;
   logic signed [31:0] rsp_out_value;
   logic rsp_last_of_column;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [4:0] csr_data = 0;

   strided_conv1d_stream DUT (.*);

   initial forever #5 clock = ~clock;

   op_type pending[$];
   conv_out_type conv_expected[$];
   int errors = 0;
   int rsp_count = 0;
   bit quiet = 0;

   // predictor state
   shortint wt[16][8][8];
   shortint bias[16];
   shortint hist[8][8];
   int seen, phase, pos, slot;
   logic [4:0] r_kernel = 3, r_step = 1, r_inch = 8, r_outch = 16;

   function automatic int clampv(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void clear_seq();
      foreach (hist[i, j]) hist[i][j] = 0;
      seen = 0; phase = 0; pos = 0; slot = 0;
   endfunction

   function automatic void predict_word(op_type w);
      int k, s, nin, nout;
      longint acc;
      conv_out_type r;
      case (w.cmd)
         CMD_WEIGHT: wt[w.filt][w.chan][w.tap] = w.val;
         CMD_BIAS:   bias[w.filt] = w.val;
         CMD_SAMPLE: begin
            hist[slot][w.chan] = w.val;
            if (w.col_end) begin
               k = clampv(r_kernel[3:0], 8);
               s = clampv(r_step[3:0], 8);
               nin = clampv(r_inch[3:0], 8);
               nout = clampv(r_outch, 16);
               slot = (slot + 1) % 8;
               if (seen < 65535) seen++;
               if (seen >= k) begin
                  if (phase == 0) begin
                     for (int f = 0; f < nout; f++) begin
                        acc = longint'(bias[f]) * 256;
                        for (int c = 0; c < nin; c++)
                           for (int t = 0; t < k; t++)
                              acc += longint'(hist[(slot + 8 - k + t) % 8][c]) *
                                     longint'(wt[f][c][t]);
                        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                        r.filt = 4'(f); r.pos = 16'(pos); r.val = acc[31:0];
                        r.last = (f + 1 == nout);
                        conv_expected = {conv_expected, r};
                     end
                     if (pos < 65535) pos++;
                  end
                  phase = (phase + 1) % s;
               end
               for (int c = 0; c < 8; c++) hist[slot][c] = 0;
            end
         end
         default: ;
      endcase
      if (w.seq_end) clear_seq();
   endfunction

   function automatic void apply_cfg(reg_idx_type i, logic [4:0] d);
      case (i)
         REG_KERNEL_LEN:   r_kernel = d[3:0];
         REG_STEP_LEN:     r_step = d[3:0];
         REG_IN_CHANNELS:  r_inch = d[3:0];
         REG_OUT_CHANNELS: r_outch = d;
         default: ;
      endcase
   endfunction

   task automatic report(string what, conv_out_type got, conv_out_type want);
      errors++;
      $display("mismatch %s: got f%0d p%0d v%0d l%0d, want f%0d p%0d v%0d l%0d", what,
               got.filt, got.pos, got.val, got.last, want.filt, want.pos, want.val,
               want.last);
   endtask

   // driver
   int send_gap = 0, settle = 0;
   always @(posedge clock) begin
      bit sending, cfg_on;
      op_type o;
      sending = req_valid;
      cfg_on = csr_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            o.cmd = cmd_type'(req_cmd); o.filt = req_filter_index;
            o.chan = req_channel_index; o.tap = req_tap_index; o.val = req_value;
            o.col_end = req_column_end; o.seq_end = req_sequence_end;
            predict_word(o);
            sending = 0;
         end
         if (csr_valid && csr_ready) begin
            apply_cfg(reg_idx_type'(csr_index), csr_data);
            cfg_on = 0;
         end
         if (!sending && !cfg_on) begin
            if (send_gap > 0) send_gap--;
            else if (settle > 0) settle--;
            else if (pending.size() > 0) begin
               o = pending[0];
               case (o.kind)
                  OP_DRAIN: if (conv_expected.size() == 0) begin
                     void'(pending.pop_front());
                     settle = 40;
                  end
                  OP_CFG: begin
                     void'(pending.pop_front());
                     cfg_on = 1;
                     csr_index <= o.ridx;
                     csr_data <= o.rdata;
                  end
                  default: if (!quiet && $urandom_range(0, 7) == 0)
                     send_gap = $urandom_range(1, 19);
                  else begin
                     void'(pending.pop_front());
                     sending = 1;
                     req_cmd <= o.cmd; req_filter_index <= o.filt;
                     req_channel_index <= o.chan; req_tap_index <= o.tap;
                     req_value <= o.val; req_column_end <= o.col_end;
                     req_sequence_end <= o.seq_end;
                  end
               endcase
            end
         end
      end
      req_valid <= sending;
      csr_valid <= cfg_on;
   end

   // monitor and receiver
   int recv_burst = 0, long_hold = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      conv_out_type got, want;
      bit stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.filt = rsp_out_filter; got.pos = rsp_out_position;
         got.val = rsp_out_value; got.last = rsp_last_of_column;
         rsp_count++;
         if (conv_expected.size() == 0) begin
            want = '{default: 0};
            report("unexpected word", got, want);
         end else begin
            want = conv_expected.pop_front();
            if (got.filt !== want.filt) report("out_filter", got, want);
            if (got.pos !== want.pos) report("out_position", got, want);
            if (got.val !== want.val) report("out_value", got, want);
            if (got.last !== want.last) report("last_of_column", got, want);
         end
      end
      if (!hold_done && rsp_count >= 20) begin
         hold_done = 1;
         long_hold = 600;
      end
      if (long_hold > 0) begin
         long_hold--; stall_next = 1;
      end else if (recv_burst > 0) begin
         recv_burst--; stall_next = 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         recv_burst = $urandom_range(0, 18); stall_next = 1;
      end else stall_next = 0;
      rsp_stall <= stall_next;
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 8000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stimulus
   int g_inch = 8;

   function automatic logic [15:0] rnd_val();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void push_word(cmd_type c, int f, int ch, int t, logic [15:0] v,
                                     bit ce, bit se);
      op_type o;
      o.kind = OP_WORD; o.cmd = c; o.filt = 4'(f); o.chan = 3'(ch); o.tap = 3'(t);
      o.val = v; o.col_end = ce; o.seq_end = se; o.ridx = REG_KERNEL_LEN; o.rdata = '0;
      pending = {pending, o};
   endfunction

   function automatic void push_cfg(int k, int s, int ic, int oc);
      op_type o;
      o.kind = OP_DRAIN; o.cmd = CMD_NONE; o.filt = '0; o.chan = '0; o.tap = '0;
      o.val = '0; o.col_end = 0; o.seq_end = 0; o.ridx = REG_KERNEL_LEN; o.rdata = '0;
      pending = {pending, o};
      o.kind = OP_CFG;
      o.ridx = REG_KERNEL_LEN; o.rdata = 5'(k); pending = {pending, o};
      o.ridx = REG_STEP_LEN; o.rdata = 5'(s); pending = {pending, o};
      o.ridx = REG_IN_CHANNELS; o.rdata = 5'(ic); pending = {pending, o};
      o.ridx = REG_OUT_CHANNELS; o.rdata = 5'(oc); pending = {pending, o};
      g_inch = clampv(ic & 15, 8);
   endfunction

   // fixed != 0: every sample takes that value
   function automatic void gen_seq(int ncols, bit broken, int fixed);
      int ch;
      logic [15:0] v;
      for (int col = 0; col < ncols; col++)
         for (int c = 0; c < g_inch; c++) begin
            if (!fixed && c != g_inch - 1 && $urandom_range(0, 11) == 0) continue;
            ch = (!fixed && $urandom_range(0, 15) == 0) ? $urandom_range(0, 7) : c;
            v = fixed ? fixed[15:0] : rnd_val();
            if (broken && $urandom_range(0, 20) == 0) begin
               push_word(CMD_SAMPLE, 0, ch, 0, v, $urandom_range(0, 1), 1);
               return;
            end
            push_word(CMD_SAMPLE, 0, ch, 0, v, c == g_inch - 1,
                      col == ncols - 1 && c == g_inch - 1);
         end
   endfunction

   function automatic void gen_noise();
      case ($urandom_range(0, 3))
         0: push_word(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
         1: push_word(CMD_WEIGHT, $urandom, $urandom, $urandom, rnd_val(), 0, 0);
         2: push_word(CMD_BIAS, $urandom, 0, 0, rnd_val(), 0, 0);
         default: push_word(CMD_SAMPLE, 0, $urandom, 0, rnd_val(), $urandom, 0);
      endcase
   endfunction

   initial begin
      logic [15:0] v;
      // every bias; tap 0 of channel 0 for all filters, all taps and channels of
      // filter 0 along its first row and column, and filters 0-1 over 2 channels, 2 taps
      for (int f = 0; f < 16; f++)
         push_word(CMD_BIAS, f, 0, 0, rnd_val(), 0, 0);
      for (int f = 0; f < 16; f++)
         for (int c = 0; c < 8; c++)
            for (int t = 0; t < 8; t++) begin
               if (!((f == 0 && (c == 0 || t == 0)) || (c == 0 && t == 0) ||
                     (f < 2 && c < 2 && t < 2))) continue;
               v = (f == 0 && c == 0) ? 16'h8000 : rnd_val();
               push_word(CMD_WEIGHT, f, c, t, v, 0, 0);
            end
      // saturation both ways over eight taps, unknown command
      push_cfg(8, 1, 1, 1);
      gen_seq(8, 0, 16'h8000);
      gen_seq(8, 0, 16'h7fff);
      push_word(CMD_NONE, 15, 7, 7, 16'hffff, 1, 0);
      // short sequence, then a full one
      push_cfg(2, 1, 2, 2);
      gen_seq(1, 0, 16'h0100);
      gen_seq(4, 0, 0);
      // register values out of range
      push_cfg(0, 0, 0, 31);
      gen_seq(3, 0, 0);
      push_cfg(15, 15, 1, 1);
      gen_seq(10, 0, 0);
      push_cfg(1, 3, 15, 1);
      gen_seq(3, 0, 0);
      // step shortened while the stride phase lies past its new end
      push_cfg(1, 8, 1, 1);
      for (int n = 0; n < 4; n++) push_word(CMD_SAMPLE, 0, 0, 0, rnd_val(), 1, 0);
      push_cfg(1, 2, 1, 1);
      gen_seq(3, 0, 0);
      // small random shapes, broken sequences and stray words
      for (int p = 0; p < 4; p++) begin
         push_cfg($urandom_range(0, 2), $urandom_range(0, 15), $urandom_range(0, 2),
                  $urandom_range(0, 2));
         gen_seq($urandom_range(1, 6), $urandom_range(0, 2) == 0, 0);
         gen_noise();
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      wait (pending.size() < 40);
      quiet = 1;
      wait (pending.size() == 0 && !req_valid && conv_expected.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && conv_expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/sconv_pkg.sv
hw/rtl/sconv_wmem.sv
hw/rtl/sconv_hist.sv
hw/rtl/sconv_mac.sv
hw/rtl/strided_conv1d_stream.sv
tb/testbench.sv
